### sv/apt_pkg.sv
`default_nettype none

package apt_pkg;

    // Frame store geometry
    localparam int MAX_PIXELS = 4096;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int TOTAL_W    = $clog2(MAX_PIXELS + 1);

    // Sample, mask and percentage widths
    localparam int SAMPLE_W   = 16;
    localparam int CHANNELS   = 4;
    localparam int PIXEL_W    = SAMPLE_W * CHANNELS;
    localparam int PCT_W      = 7;
    localparam int PCT_SCALE  = 100;
    localparam int REM_W      = TOTAL_W + PCT_W - 1;
    localparam int STEP_W     = $clog2(PCT_W);

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    // Configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET_PERCENT = 4'd0,
        REG_CUT_ENABLE     = 4'd1,
        REG_CUT_LEVEL      = 4'd2,
        REG_CHANNEL_COUNT  = 4'd3
    } cfg_reg_e;

    localparam logic [PCT_W-1:0]    TARGET_RESET = 7'd40;
    localparam logic                CUT_EN_RESET = 1'b1;
    localparam logic [SAMPLE_W-1:0] CUT_LV_RESET = 16'd57344;
    localparam logic [2:0]          CHAN_RESET   = 3'd3;

    // Item operations
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [SAMPLE_W-1:0] chan0;
        logic [SAMPLE_W-1:0] chan1;
        logic [SAMPLE_W-1:0] chan2;
        logic [SAMPLE_W-1:0] chan3;
        logic [11:0]         read_index;
        logic                frame_end;
    } in_item_t;

    typedef struct packed {
        logic                is_readout;
        logic [SAMPLE_W-1:0] found_threshold;
        logic [PCT_W-1:0]    found_percent;
        logic [SAMPLE_W-1:0] mask_value;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic read;
        logic pass_init;
        logic div_init;
        logic div_step;
        logic decide;
        logic send_report;
        logic send_read;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_busy;
        logic div_last;
        logic stop;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic                hit;
        logic [SAMPLE_W-1:0] value;
    } mask_t;

    // Channel mask of one pixel at a threshold, with the optional cut
    function automatic mask_t pixel_mask(input logic [PIXEL_W-1:0]  px,
                                         input logic [SAMPLE_W-1:0] thr,
                                         input logic                cut_en,
                                         input logic [SAMPLE_W-1:0] cut_lv,
                                         input logic [2:0]          chan_cnt);
        logic [CHANNELS-1:0] bits;
        logic [SAMPLE_W-1:0] m;
        mask_t               res;
        for (int c = 0; c < CHANNELS; c++) begin
            bits[c] = (px[c*SAMPLE_W +: SAMPLE_W] >= thr);
        end
        unique case (chan_cnt)
            3'd0, 3'd1: m = {bits[0],   15'd0};
            3'd2:       m = {bits[1:0], 14'd0};
            3'd3:       m = {bits[2:0], 13'd0};
            default:    m = {bits[3:0], 12'd0};
        endcase
        res.hit   = cut_en && (m >= cut_lv);
        res.value = cut_en ? (res.hit ? SAMPLE_MAX : '0) : m;
        return res;
    endfunction

endpackage

`default_nettype wire

### sv/adaptive_percent_threshold.sv
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    apt_pkg::in_item_t  (load or mask read)
// m_        out        m_valid / m_ready    apt_pkg::out_item_t (report or mask)
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// A mask read passes through a fetch state and then a send state, which puts its answer in
// the output register once that is free; the input is ready again from then on.
// The search after the frame-end load runs up to 16 passes; each pass reads the N stored
// pixels, one frame store read a cycle, and then runs the divider.
// Synchronous active-low reset; the frame store itself is not cleared.
// A stalled result sits in the output register; the next item is still taken,
// but a finished read or search waits there until the output register is free.
`default_nettype none

module adaptive_percent_threshold (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire apt_pkg::in_item_t                 s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output apt_pkg::out_item_t                     m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [apt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [apt_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import apt_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    apt_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_op        (s_data.operation),
        .s_frame_end (s_data.frame_end),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    apt_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

### sv/apt_ctrl.sv
`default_nettype none

module apt_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    input  wire logic            s_op,
    input  wire logic            s_frame_end,
    output logic                 s_ready,
    input  wire apt_pkg::status_t status,
    output apt_pkg::cmd_t        cmd
);
    import apt_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_RD_FETCH  = 8'b0000_0010,
        ST_RD_SEND   = 8'b0000_0100,
        ST_SR_PASS   = 8'b0000_1000,
        ST_SR_SCAN   = 8'b0001_0000,
        ST_SR_DIV    = 8'b0010_0000,
        ST_SR_DECIDE = 8'b0100_0000,
        ST_SR_REPORT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == OP_READ) begin
                        cmd.read   = 1'b1;
                        state_next = ST_RD_FETCH;
                    end else begin
                        cmd.load = 1'b1;
                        if (s_frame_end) state_next = ST_SR_PASS;
                    end
                end
            end
            ST_RD_FETCH: state_next = ST_RD_SEND;
            ST_RD_SEND: begin
                if (status.out_free) begin
                    cmd.send_read = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SR_PASS: begin
                cmd.pass_init = 1'b1;
                state_next    = ST_SR_SCAN;
            end
            ST_SR_SCAN: begin
                if (!status.scan_busy) begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_SR_DIV;
                end
            end
            ST_SR_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) state_next = ST_SR_DECIDE;
            end
            ST_SR_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = status.stop ? ST_SR_REPORT : ST_SR_PASS;
            end
            ST_SR_REPORT: begin
                if (status.out_free) begin
                    cmd.send_report = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### sv/apt_dp.sv
`default_nettype none

module apt_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire apt_pkg::in_item_t                 s_data,
    input  wire logic                              cfg_valid,
    input  wire logic [apt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [apt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire apt_pkg::cmd_t                     cmd,
    output apt_pkg::status_t                       status,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output apt_pkg::out_item_t                     m_data
);
    import apt_pkg::*;

    // Configuration registers
    logic [PCT_W-1:0]    target_reg;
    logic                cut_en_reg;
    logic [SAMPLE_W-1:0] cut_level_reg;
    logic [2:0]          chan_cnt_reg;

    // Frame and search state
    logic [PIXEL_W-1:0]  pixel_mem [MAX_PIXELS];
    logic [PIXEL_W-1:0]  rd_data_reg;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                closed_reg;
    logic [SAMPLE_W-1:0] low_reg, high_reg, trial_reg;
    logic [SAMPLE_W-1:0] low_next, high_next;
    logic [TOTAL_W-1:0]  count_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                issue_reg, dvld_reg, in_range_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [PCT_W-1:0]    quo_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [PCT_W-1:0]    pct_reg;
    logic                m_valid_reg;
    out_item_t           m_data_reg;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic                addr_last;
    logic [REM_W-1:0]    div_sub;
    logic [PCT_W-1:0]    pct_now;
    logic                pct_low, pct_within;
    logic [SAMPLE_W:0]   bound_sum;
    mask_t               mask_res;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg    <= TARGET_RESET;
            cut_en_reg    <= CUT_EN_RESET;
            cut_level_reg <= CUT_LV_RESET;
            chan_cnt_reg  <= CHAN_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TARGET_PERCENT: target_reg    <= cfg_data[PCT_W-1:0];
                REG_CUT_ENABLE:     cut_en_reg    <= cfg_data[0];
                REG_CUT_LEVEL:      cut_level_reg <= cfg_data[SAMPLE_W-1:0];
                REG_CHANNEL_COUNT:  chan_cnt_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Pixel loads: a closed frame restarts at position zero, a full store drops
    assign wr_en   = cmd.load && (closed_reg || (total_reg < TOTAL_W'(MAX_PIXELS)));
    assign wr_addr = closed_reg ? '0 : total_reg[ADDR_W-1:0];

    always_comb begin
        total_next = total_reg;
        if (cmd.load) begin
            if (closed_reg) total_next = TOTAL_W'(1);
            else if (wr_en) total_next = total_reg + TOTAL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg  <= '0;
            closed_reg <= 1'b0;
        end else if (cmd.load) begin
            total_reg  <= total_next;
            closed_reg <= s_data.frame_end;
        end
    end

    // Frame store, one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pixel_mem[wr_addr] <= {s_data.chan3, s_data.chan2, s_data.chan1, s_data.chan0};
        end
        rd_data_reg <= pixel_mem[addr_reg];
    end

    assign mask_res = pixel_mask(rd_data_reg, trial_reg, cut_en_reg, cut_level_reg,
                                 chan_cnt_reg);

    // Scan sweep: issue one address a cycle, count its hits in the cycle after
    assign addr_last = ({1'b0, addr_reg} == (total_reg - TOTAL_W'(1)));
    assign bound_sum = {1'b0, low_reg} + {1'b0, high_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg <= 1'b0;
            dvld_reg  <= 1'b0;
        end else begin
            if (cmd.pass_init)            issue_reg <= 1'b1;
            else if (issue_reg && addr_last) issue_reg <= 1'b0;
            dvld_reg <= issue_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            addr_reg     <= s_data.read_index[ADDR_W-1:0];
            in_range_reg <= ({1'b0, s_data.read_index} < total_reg);
        end else if (cmd.pass_init) begin
            addr_reg <= '0;
        end else if (issue_reg && !addr_last) begin
            addr_reg <= addr_reg + ADDR_W'(1);
        end
        if (cmd.pass_init)                count_reg <= '0;
        else if (dvld_reg && mask_res.hit) count_reg <= count_reg + TOTAL_W'(1);
    end

    // Percentage: restoring division of count*100 by the total, one bit a cycle
    assign div_sub = REM_W'(total_reg) << step_reg;

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg  <= REM_W'(count_reg) * REM_W'(PCT_SCALE);
            quo_reg  <= '0;
            step_reg <= STEP_W'(PCT_W - 1);
        end else if (cmd.div_step) begin
            if (rem_reg >= div_sub) begin
                rem_reg <= rem_reg - div_sub;
                quo_reg <= quo_reg | (PCT_W'(1) << step_reg);
            end
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    // Bound update after each pass; the upper bound saturates at zero
    assign pct_now    = (total_reg == '0) ? '0 : quo_reg;
    assign pct_low    = (pct_now < target_reg);
    assign pct_within = (({1'b0, pct_now} + 8'd1) >= {1'b0, target_reg}) &&
                        ({1'b0, pct_now} <= ({1'b0, target_reg} + 8'd1));

    always_comb begin
        low_next  = low_reg;
        high_next = high_reg;
        if (!pct_within) begin
            if (pct_low) high_next = (trial_reg == '0) ? '0 : trial_reg - SAMPLE_W'(1);
            else         low_next  = trial_reg + SAMPLE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg   <= '0;
            high_reg  <= SAMPLE_MAX;
            trial_reg <= '0;
        end else begin
            if (cmd.load && s_data.frame_end) begin
                low_reg  <= '0;
                high_reg <= SAMPLE_MAX;
            end else if (cmd.decide) begin
                low_reg  <= low_next;
                high_reg <= high_next;
            end
            if (cmd.pass_init) trial_reg <= bound_sum[SAMPLE_W:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) pct_reg <= pct_now;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.send_report || cmd.send_read) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.send_report) begin
            m_data_reg.is_readout      <= 1'b0;
            m_data_reg.found_threshold <= trial_reg;
            m_data_reg.found_percent   <= pct_reg;
            m_data_reg.mask_value      <= '0;
        end else if (cmd.send_read) begin
            m_data_reg.is_readout      <= 1'b1;
            m_data_reg.found_threshold <= '0;
            m_data_reg.found_percent   <= '0;
            m_data_reg.mask_value      <= in_range_reg ? mask_res.value : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Status to the controller
    assign status.scan_busy = issue_reg || dvld_reg;
    assign status.div_last  = (step_reg == '0);
    assign status.stop      = pct_within || !(low_next < high_next);
    assign status.out_free  = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

### sv/apt_checker.sv
`default_nettype none

module apt_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire apt_pkg::out_item_t m_data
);
    import apt_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A report carries no mask
    a_report_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_readout |-> m_data.mask_value == '0)
        else $error("report with non-zero mask");

    // A read answer carries no search figures
    a_read_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_readout |->
            m_data.found_threshold == '0 && m_data.found_percent == '0)
        else $error("read answer with search figures");

    // The percentage never exceeds the full scale
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.found_percent <= PCT_W'(PCT_SCALE))
        else $error("percentage out of range");

endmodule

bind adaptive_percent_threshold apt_checker u_apt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
